// ===== design/lca_pkg.sv =====
// Shared types and constants for the life cellular automaton block.
package lca_pkg;

   localparam int ROW_W   = 5;
   localparam int COL_W   = 5;
   localparam int BITS_W  = 32;

   // Action codes carried by an input item
   localparam logic [1:0] ACT_GEN    = 2'd0;
   localparam logic [1:0] ACT_TOGGLE = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   // Operation codes after classification
   localparam logic [1:0] OP_GEN    = 2'd0;
   localparam logic [1:0] OP_TOGGLE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // B3/S23 neighbor counts
   localparam logic [3:0] NB_SURVIVE = 4'd2;
   localparam logic [3:0] NB_BIRTH   = 4'd3;

   typedef struct packed {
      logic [1:0]       action;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } req_type;

   typedef struct packed {
      logic [BITS_W-1:0] row_bits;
      logic              cell_state;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             row_ok;
      logic             col_ok;
   } cmd_type;

endpackage

// ===== design/life_cellular_automaton.sv =====
// Top level of the B3/S23 life cellular automaton: front queue plus grid engine.
// Flow: a toggle or read passes through the front queue, a row read of the grid
//   RAM and the result register; a generation sweeps the grid RAM one row per cycle.
// Throughput: one item at a time in the engine; a two-entry front queue keeps
//   taking items, until full, while the engine works or a result waits to be popped.
// Reset: synchronous, active high; empties both queues and marks every row dead.
module life_cellular_automaton #(
   parameter int GRID_ROWS = 32,
   parameter int GRID_COLS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  lca_pkg::req_type req_item,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output lca_pkg::rsp_type rsp_item
);

   // classified item handed from the front queue to the engine
   lca_pkg::cmd_type cmd;
   logic             cmd_valid;
   logic             cmd_pop;

   // Front: decodes action (unused code behaves as read) and range-checks
   // row and column before queuing the item.
   lca_front #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   // Back: grid RAM with per-row valid bits. A generation sweeps rows in
   // order through a three-row window and writes each new row back in place
   // once the row below it has been read, so only the old generation is used.
   // Cells past any edge count as dead. The result register holds one item.
   lca_back #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== design/lca_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lca_front.sv =====
// Front end: accepts items, classifies them and queues them for the engine.
module lca_front #(
   parameter int GRID_ROWS = 32,
   parameter int GRID_COLS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  lca_pkg::req_type req_item,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output lca_pkg::cmd_type cmd
);

   lca_pkg::cmd_type q_ff [2];
   lca_pkg::cmd_type q_in [2];
   logic [1:0]       cnt_ff, cnt_in;
   lca_pkg::cmd_type cls;
   logic             push, pop;
   logic [1:0]       wr_pos;

   always_comb begin
      cls.row    = req_item.row;
      cls.col    = req_item.col;
      cls.row_ok = (7'(req_item.row) < 7'(GRID_ROWS));
      cls.col_ok = (7'(req_item.col) < 7'(GRID_COLS));
      case (req_item.action)
         lca_pkg::ACT_GEN:    cls.op = lca_pkg::OP_GEN;
         lca_pkg::ACT_TOGGLE: cls.op = lca_pkg::OP_TOGGLE;
         lca_pkg::ACT_READ:   cls.op = lca_pkg::OP_READ;
         default:             cls.op = lca_pkg::OP_READ;   // unused code acts as read
      endcase
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign push      = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[0];
   assign wr_pos    = cnt_ff - {1'b0, pop};

   always_comb begin
      q_in[0] = pop ? q_ff[1] : q_ff[0];
      q_in[1] = q_ff[1];
      if (push) begin
         if (wr_pos == 2'd0) begin
            q_in[0] = cls;
         end else begin
            q_in[1] = cls;
         end
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

endmodule

// ===== design/lca_back.sv =====
// Back end: runs toggle, read and row-swept generation over the grid RAM.
module lca_back #(
   parameter int GRID_ROWS = 32,
   parameter int GRID_COLS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  lca_pkg::cmd_type cmd,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output lca_pkg::rsp_type rsp_item
);

   localparam int RA = $clog2(GRID_ROWS);
   localparam int SW = $clog2(GRID_ROWS + 1);
   localparam int BITS_W_L = lca_pkg::BITS_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROW  = 2'd1;
   localparam logic [1:0] ST_GEN  = 2'd2;

   logic [1:0]            state_ff, state_in;
   lca_pkg::cmd_type      cur_ff, cur_in;
   logic [SW-1:0]         step_ff, step_in;
   logic [GRID_COLS-1:0]  up_ff, up_in, mid_ff, mid_in;
   logic [GRID_COLS-1:0]  res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [GRID_ROWS-1:0]  vld_ff, vld_in;
   logic [RA-1:0]         rd_addr_ff, rd_addr_in;

   logic                  wr_en;
   logic [RA-1:0]         wr_addr;
   logic [GRID_COLS-1:0]  wr_data;
   logic [GRID_COLS-1:0]  ram_q, rd_row, dn_row, gen_row, tog_row;
   logic [GRID_COLS+1:0]  up_p, mid_p, dn_p;
   logic [BITS_W_L-1:0]   res_ext;

   lca_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_in),
      .rd_data (ram_q)
   );

   // rows never written read as dead
   assign rd_row = vld_ff[rd_addr_ff] ? ram_q : '0;

   // window below the row being computed; zero past the last row
   assign dn_row = (step_ff < SW'(GRID_ROWS)) ? rd_row : '0;
   assign up_p   = {1'b0, up_ff, 1'b0};
   assign mid_p  = {1'b0, mid_ff, 1'b0};
   assign dn_p   = {1'b0, dn_row, 1'b0};

   always_comb begin
      logic [3:0] nb;
      gen_row = '0;
      for (int c = 0; c < GRID_COLS; c++) begin
         nb = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
            + 4'(mid_p[c]) + 4'(mid_p[c+2])
            + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
         gen_row[c] = (nb == lca_pkg::NB_BIRTH) ||
                      (mid_p[c+1] && (nb == lca_pkg::NB_SURVIVE));
      end
   end

   assign tog_row = cur_ff.col_ok
                  ? (rd_row ^ (GRID_COLS'(1) << cur_ff.col)) : rd_row;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      up_in        = up_ff;
      mid_in       = mid_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      vld_in       = vld_ff;
      rd_addr_in   = rd_addr_ff;
      wr_en        = 1'b0;
      wr_addr      = RA'(cur_ff.row);
      wr_data      = tog_row;
      cmd_pop      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               res_in  = '0;
               if (cmd.op == lca_pkg::OP_GEN) begin
                  rd_addr_in = '0;
                  step_in    = '0;
                  up_in      = '0;
                  mid_in     = '0;
                  state_in   = ST_GEN;
               end else if (cmd.row_ok) begin
                  rd_addr_in = RA'(cmd.row);
                  state_in   = ST_ROW;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_ROW: begin
            if (cur_ff.op == lca_pkg::OP_TOGGLE) begin
               wr_en           = 1'b1;
               vld_in[wr_addr] = 1'b1;
               res_in          = tog_row;
            end else begin
               res_in = rd_row;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_GEN: begin
            if (step_ff < SW'(GRID_ROWS - 1)) begin
               rd_addr_in = RA'(step_ff + SW'(1));
            end
            if (step_ff != '0) begin
               wr_en           = 1'b1;
               wr_addr         = RA'(step_ff - SW'(1));
               wr_data         = gen_row;
               vld_in[wr_addr] = 1'b1;
               if (cur_ff.row_ok && (wr_addr == RA'(cur_ff.row))) begin
                  res_in = gen_row;
               end
            end
            up_in   = mid_ff;
            mid_in  = dn_row;
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(GRID_ROWS)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_ff       <= vld_in;
      end
      cur_ff     <= cur_in;
      step_ff    <= step_in;
      up_ff      <= up_in;
      mid_ff     <= mid_in;
      res_ff     <= res_in;
      rd_addr_ff <= rd_addr_in;
   end

   assign res_ext            = BITS_W_L'(res_ff);
   assign rsp_empty          = !rsp_valid_ff;
   assign rsp_item.row_bits  = res_ext;
   assign rsp_item.cell_state = cur_ff.col_ok && res_ext[cur_ff.col];

endmodule
